// ===== hdl/bba_pkg.sv =====
// bba_pkg: shared types, field widths, status and command codes for the buddy allocator.
// Used by bba_ctrl, bba_dp and buddy_block_allocator_core. No dependencies.
package bba_pkg;

   localparam int SIZE_W   = 16;
   localparam int OFF_W    = 16;
   localparam int ORD_W    = 5;
   localparam int MSIZE_W  = 17;
   localparam int STAT_W   = 2;
   localparam int ALIGN_SH = 5;

   localparam logic [STAT_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_NO_MEM   = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_BAD_FREE = 2'd2;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam logic [MSIZE_W-1:0] WHOLE_POOL_SIZE = 17'h10000;

   typedef enum logic [4:0] {
      OP_IDLE,
      OP_CLEAR,
      OP_LOAD,
      OP_RD_ROOT,
      OP_ROOT_TAKE,
      OP_DESC_RD,
      OP_DESC_STEP,
      OP_DESC_DONE,
      OP_CHK_RD,
      OP_CHK_NEXT,
      OP_MRG_INIT,
      OP_MRG_RD,
      OP_MRG_STEP,
      OP_MRG_FIN,
      OP_UP_SIB,
      OP_UP_CUR,
      OP_UP_ROOT,
      OP_RES_OOM,
      OP_RES_BAD
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic pre_bad;
      logic is_free;
      logic root_found;
      logic at_k;
      logic at_top;
      logic chk_bad;
      logic buddy_free;
   } dp_stat_type;

   function automatic logic [ORD_W-1:0] ceil_log2(input logic [MSIZE_W-1:0] x);
      logic [MSIZE_W-1:0] v;
      logic [ORD_W-1:0]   n;
      v = x - 1'b1;
      n = '0;
      for (int i = 0; i < MSIZE_W; i++) begin
         if (v[i]) n = ORD_W'(i + 1);
      end
      return n;
   endfunction

endpackage

// ===== hdl/bba_ram.sv =====
// bba_ram: generic single write port, single read port RAM with registered read data.
// No dependencies.
module bba_ram #(
   parameter int WIDTH = 11,
   parameter int DEPTH = 2047
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/bba_ctrl.sv =====
// bba_ctrl: sequencer for the buddy allocator; clear pass, search, split, check, merge, update.
// Depends on bba_pkg for the datapath command and status structs.
module bba_ctrl
   import bba_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_PRE,
      S_ROOT,
      S_DESC_CHK,
      S_DESC_WAIT,
      S_CHK_RD,
      S_CHK_WAIT,
      S_MRG_CHK,
      S_MRG_WAIT,
      S_UP1,
      S_UP2,
      S_RESP
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd.op   = OP_IDLE;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.op = OP_CLEAR;
            if (stat.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = S_PRE;
            end
         end
         S_PRE: begin
            if (stat.pre_bad) begin
               cmd.op   = stat.is_free ? OP_RES_BAD : OP_RES_OOM;
               state_in = S_RESP;
            end else if (stat.is_free) begin
               cmd.op   = OP_CHK_RD;
               state_in = S_CHK_WAIT;
            end else begin
               cmd.op   = OP_RD_ROOT;
               state_in = S_ROOT;
            end
         end
         S_ROOT: begin
            if (stat.root_found) begin
               cmd.op   = OP_ROOT_TAKE;
               state_in = S_DESC_CHK;
            end else begin
               cmd.op   = OP_RES_OOM;
               state_in = S_RESP;
            end
         end
         S_DESC_CHK: begin
            if (stat.at_k) begin
               cmd.op   = OP_DESC_DONE;
               state_in = S_UP1;
            end else begin
               cmd.op   = OP_DESC_RD;
               state_in = S_DESC_WAIT;
            end
         end
         S_DESC_WAIT: begin
            cmd.op   = OP_DESC_STEP;
            state_in = S_DESC_CHK;
         end
         S_CHK_RD: begin
            cmd.op   = OP_CHK_RD;
            state_in = S_CHK_WAIT;
         end
         S_CHK_WAIT: begin
            if (stat.chk_bad) begin
               cmd.op   = OP_RES_BAD;
               state_in = S_RESP;
            end else if (stat.at_top) begin
               cmd.op   = OP_MRG_INIT;
               state_in = S_MRG_CHK;
            end else begin
               cmd.op   = OP_CHK_NEXT;
               state_in = S_CHK_RD;
            end
         end
         S_MRG_CHK: begin
            if (stat.at_top) begin
               cmd.op   = OP_MRG_FIN;
               state_in = S_UP1;
            end else begin
               cmd.op   = OP_MRG_RD;
               state_in = S_MRG_WAIT;
            end
         end
         S_MRG_WAIT: begin
            if (stat.buddy_free) begin
               cmd.op   = OP_MRG_STEP;
               state_in = S_MRG_CHK;
            end else begin
               cmd.op   = OP_MRG_FIN;
               state_in = S_UP1;
            end
         end
         S_UP1: begin
            if (stat.at_top) begin
               cmd.op   = OP_UP_ROOT;
               state_in = S_RESP;
            end else begin
               cmd.op   = OP_UP_SIB;
               state_in = S_UP2;
            end
         end
         S_UP2: begin
            cmd.op   = OP_UP_CUR;
            state_in = S_UP1;
         end
         S_RESP: begin
            if (rsp_ready) state_in = S_IDLE;
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
      // a new limit rebuilds the free map from scratch
      if (csr_wr_en) state_in = S_CLEAR;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);

endmodule

// ===== hdl/bba_dp.sv =====
// bba_dp: datapath of the buddy allocator; limit register, size/order math, tree walk
// registers, result registers and the node mask RAM. Depends on bba_pkg and bba_ram.
module bba_dp
   import bba_pkg::*;
#(
   parameter int POOL_ORDER = 16,
   parameter int MIN_ORDER  = 6
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [ORD_W-1:0]   csr_wr_data,
   input  logic               req_cmd,
   input  logic [SIZE_W-1:0]  req_request_size,
   input  logic [OFF_W-1:0]   req_block_offset,
   input  dp_cmd_type         cmd,
   output dp_stat_type        stat,
   output logic [STAT_W-1:0]  rsp_status,
   output logic [OFF_W-1:0]   rsp_result_offset,
   output logic [ORD_W-1:0]   rsp_block_order,
   output logic [MSIZE_W-1:0] rsp_marked_size
);

   localparam int LEVELS = POOL_ORDER - MIN_ORDER + 1;
   localparam int AW     = LEVELS;
   localparam int PW     = LEVELS - 1;
   localparam int DEPTH  = (1 << LEVELS) - 1;
   localparam int BLK_W  = MSIZE_W - ALIGN_SH;
   localparam logic [ORD_W-1:0] MIN_ORD  = ORD_W'(MIN_ORDER);
   localparam logic [ORD_W-1:0] POOL_ORD = ORD_W'(POOL_ORDER);

   // each node holds a mask of the orders that are free somewhere in its subtree
   function automatic logic [AW-1:0] node_addr(input logic [ORD_W-1:0] ord,
                                               input logic [PW-1:0] p);
      logic [ORD_W-1:0] sh;
      sh = POOL_ORD - ord;
      return ((AW'(1) << sh) - AW'(1)) + AW'(p);
   endfunction

   function automatic logic [LEVELS-1:0] lvl_bit(input logic [ORD_W-1:0] ord);
      return LEVELS'(1) << (ord - MIN_ORD);
   endfunction

   logic [ORD_W-1:0]   limit_ff, limit_in;
   logic [AW-1:0]      clr_cnt_ff, clr_cnt_in;
   logic               is_free_ff, is_free_in;
   logic [MSIZE_W-1:0] size_ff, size_in;
   logic [ORD_W-1:0]   order_ff, order_in;
   logic [OFF_W-1:0]   off_ff, off_in;
   logic [PW-1:0]      orig_pos_ff, orig_pos_in;
   logic               pre_bad_ff, pre_bad_in;
   logic [ORD_W-1:0]   j_ff, j_in;
   logic [PW-1:0]      pos_ff, pos_in;
   logic [ORD_W-1:0]   k_ff, k_in;
   logic [ORD_W-1:0]   split_ff, split_in;
   logic [LEVELS-1:0]  cur_mask_ff, cur_mask_in;
   logic [STAT_W-1:0]  res_status_ff, res_status_in;
   logic [OFF_W-1:0]   res_off_ff, res_off_in;
   logic [ORD_W-1:0]   res_order_ff, res_order_in;

   logic              mem_wr_en;
   logic [AW-1:0]     mem_wr_addr;
   logic [LEVELS-1:0] mem_wr_data;
   logic [AW-1:0]     mem_rd_addr;
   logic [LEVELS-1:0] mem_rd_data;

   logic [BLK_W-1:0]   alloc_blocks;
   logic [MSIZE_W-1:0] alloc_size;
   logic [MSIZE_W-1:0] free_size;
   logic [MSIZE_W-1:0] new_size;
   logic [ORD_W-1:0]   raw_order;
   logic [ORD_W-1:0]   new_order;
   logic               align_bad;
   logic               range_bad;
   logic               new_pre_bad;
   logic [PW-1:0]      new_pos;
   logic [ORD_W-1:0]   csr_clamped;
   logic               k_found;
   logic [ORD_W-1:0]   k_sel;
   logic [PW-1:0]      sib_pos;
   logic               below_split;
   logic               has_k;

   bba_ram #(
      .WIDTH (LEVELS),
      .DEPTH (DEPTH)
   ) u_node_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // header plus alignment: one more 32 byte unit even when already aligned
   assign alloc_blocks = BLK_W'(req_request_size >> ALIGN_SH) + BLK_W'(2);
   assign alloc_size   = {alloc_blocks, {ALIGN_SH{1'b0}}};
   assign free_size    = (req_request_size == '0) ? WHOLE_POOL_SIZE
                                                  : MSIZE_W'(req_request_size);
   assign new_size     = (req_cmd == CMD_FREE) ? free_size : alloc_size;
   assign raw_order    = ceil_log2(new_size);
   assign new_order    = (raw_order < MIN_ORD) ? MIN_ORD : raw_order;
   assign align_bad    = (req_block_offset & ~({OFF_W{1'b1}} << new_order)) != '0;
   assign range_bad    = (req_block_offset >> limit_ff) != '0;
   assign new_pre_bad  = (new_order > limit_ff)
                         || ((req_cmd == CMD_FREE) && (align_bad || range_bad));
   assign new_pos      = PW'(req_block_offset >> new_order);

   always_comb begin
      if (csr_wr_data < MIN_ORD) begin
         csr_clamped = MIN_ORD;
      end else if (csr_wr_data > POOL_ORD) begin
         csr_clamped = POOL_ORD;
      end else begin
         csr_clamped = csr_wr_data;
      end
   end

   // smallest order with a free block, from the wanted order up to the limit
   always_comb begin
      k_found = 1'b0;
      k_sel   = '0;
      for (int i = LEVELS - 1; i >= 0; i--) begin
         if (mem_rd_data[i] && (ORD_W'(i) + MIN_ORD >= order_ff)
             && (ORD_W'(i) + MIN_ORD <= limit_ff)) begin
            k_found = 1'b1;
            k_sel   = ORD_W'(i) + MIN_ORD;
         end
      end
   end

   assign sib_pos     = pos_ff ^ PW'(1);
   assign below_split = (j_ff < split_ff);
   assign has_k       = (mem_rd_data & lvl_bit(k_ff)) != '0;

   assign stat.clear_last = (clr_cnt_ff == AW'(DEPTH - 1));
   assign stat.pre_bad    = pre_bad_ff;
   assign stat.is_free    = is_free_ff;
   assign stat.root_found = k_found;
   assign stat.at_k       = (j_ff == k_ff);
   assign stat.at_top     = (j_ff == limit_ff);
   assign stat.chk_bad    = (j_ff == order_ff) ? (mem_rd_data != '0)
                                               : ((mem_rd_data & lvl_bit(j_ff)) != '0);
   assign stat.buddy_free = (mem_rd_data & lvl_bit(j_ff)) != '0;

   always_comb begin
      limit_in      = limit_ff;
      clr_cnt_in    = clr_cnt_ff;
      is_free_in    = is_free_ff;
      size_in       = size_ff;
      order_in      = order_ff;
      off_in        = off_ff;
      orig_pos_in   = orig_pos_ff;
      pre_bad_in    = pre_bad_ff;
      j_in          = j_ff;
      pos_in        = pos_ff;
      k_in          = k_ff;
      split_in      = split_ff;
      cur_mask_in   = cur_mask_ff;
      res_status_in = res_status_ff;
      res_off_in    = res_off_ff;
      res_order_in  = res_order_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = '0;
      mem_wr_data   = '0;
      mem_rd_addr   = '0;
      case (cmd.op)
         OP_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_cnt_ff;
            mem_wr_data = (clr_cnt_ff == node_addr(limit_ff, '0)) ? lvl_bit(limit_ff) : '0;
            clr_cnt_in  = clr_cnt_ff + AW'(1);
         end
         OP_LOAD: begin
            is_free_in  = (req_cmd == CMD_FREE);
            size_in     = new_size;
            order_in    = new_order;
            off_in      = req_block_offset;
            orig_pos_in = new_pos;
            pre_bad_in  = new_pre_bad;
            j_in        = new_order;
            pos_in      = new_pos;
         end
         OP_RD_ROOT: begin
            mem_rd_addr = node_addr(limit_ff, '0);
         end
         OP_ROOT_TAKE: begin
            k_in   = k_sel;
            j_in   = limit_ff;
            pos_in = '0;
         end
         OP_DESC_RD: begin
            mem_rd_addr = node_addr(j_ff - ORD_W'(1), pos_ff << 1);
         end
         OP_DESC_STEP: begin
            // go left when the left child still holds a free block of order k
            pos_in = (pos_ff << 1) | PW'(!has_k);
            j_in   = j_ff - ORD_W'(1);
         end
         OP_DESC_DONE: begin
            pos_in        = pos_ff << (k_ff - order_ff);
            j_in          = order_ff;
            cur_mask_in   = '0;
            split_in      = k_ff;
            res_status_in = STATUS_OK;
            res_off_in    = OFF_W'(32'(pos_ff) << k_ff);
            res_order_in  = order_ff;
         end
         OP_CHK_RD: begin
            mem_rd_addr = node_addr(j_ff, pos_ff);
         end
         OP_CHK_NEXT: begin
            pos_in = pos_ff >> 1;
            j_in   = j_ff + ORD_W'(1);
         end
         OP_MRG_INIT: begin
            j_in   = order_ff;
            pos_in = orig_pos_ff;
         end
         OP_MRG_RD: begin
            mem_rd_addr = node_addr(j_ff, sib_pos);
            // a node swallowed by the merge holds nothing free below it;
            // the final merged node is rewritten on the way up
            mem_wr_en   = 1'b1;
            mem_wr_addr = node_addr(j_ff, pos_ff);
            mem_wr_data = '0;
         end
         OP_MRG_STEP: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = node_addr(j_ff, sib_pos);
            mem_wr_data = '0;
            pos_in      = pos_ff >> 1;
            j_in        = j_ff + ORD_W'(1);
         end
         OP_MRG_FIN: begin
            cur_mask_in   = lvl_bit(j_ff);
            split_in      = j_ff;
            res_status_in = STATUS_OK;
            res_off_in    = OFF_W'(32'(pos_ff) << j_ff);
            res_order_in  = j_ff;
         end
         OP_UP_SIB: begin
            // below the split level the sibling is a freshly split-off free half
            if (below_split) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = node_addr(j_ff, sib_pos);
               mem_wr_data = lvl_bit(j_ff);
            end else begin
               mem_rd_addr = node_addr(j_ff, sib_pos);
            end
         end
         OP_UP_CUR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = node_addr(j_ff, pos_ff);
            mem_wr_data = cur_mask_ff;
            cur_mask_in = cur_mask_ff | (below_split ? lvl_bit(j_ff) : mem_rd_data);
            pos_in      = pos_ff >> 1;
            j_in        = j_ff + ORD_W'(1);
         end
         OP_UP_ROOT: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = node_addr(j_ff, pos_ff);
            mem_wr_data = cur_mask_ff;
         end
         OP_RES_OOM: begin
            res_status_in = STATUS_NO_MEM;
            res_off_in    = '0;
            res_order_in  = order_ff;
         end
         OP_RES_BAD: begin
            res_status_in = STATUS_BAD_FREE;
            res_off_in    = off_ff;
            res_order_in  = order_ff;
         end
         default: begin
         end
      endcase
      if (csr_wr_en) begin
         limit_in   = csr_clamped;
         clr_cnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff   <= POOL_ORD;
         clr_cnt_ff <= '0;
      end else begin
         limit_ff   <= limit_in;
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      is_free_ff    <= is_free_in;
      size_ff       <= size_in;
      order_ff      <= order_in;
      off_ff        <= off_in;
      orig_pos_ff   <= orig_pos_in;
      pre_bad_ff    <= pre_bad_in;
      j_ff          <= j_in;
      pos_ff        <= pos_in;
      k_ff          <= k_in;
      split_ff      <= split_in;
      cur_mask_ff   <= cur_mask_in;
      res_status_ff <= res_status_in;
      res_off_ff    <= res_off_in;
      res_order_ff  <= res_order_in;
   end

   assign rsp_status        = res_status_ff;
   assign rsp_result_offset = res_off_ff;
   assign rsp_block_order   = res_order_ff;
   assign rsp_marked_size   = size_ff;

endmodule

// ===== hdl/buddy_block_allocator_core.sv =====
// Buddy block allocator over a pool of 2^limit bytes, one request at a time.
// Request channel (req_*): cmd 0 allocates request_size user bytes, cmd 1 frees the block
// at block_offset with the marked size given back at allocation (0 means 64 KiB).
// Response channel (rsp_*): status (ok, out of memory, invalid free), offset, order and
// marked size of the block; one response per request, in order.
// csr_wr_en/csr_wr_data set the top order limit (clamped to MIN_ORDER..POOL_ORDER)
// and rebuild the free map as one whole free pool.
// An allocation takes the smallest free order k found in the root mask, walks down to a
// free block of order k, splits it down to the wanted order and rewrites the masks in the
// single node RAM up to the root; a free checks each level up to the limit, merges with
// free buddies and then rewrites the masks up to the root. An early error skips the walk.
// After reset and after each csr write a clearing pass writes every node,
// 2^(POOL_ORDER-MIN_ORDER+1)-1 of them (2047 by default), with req_ready low.
// req_ready is high only when no request is in flight; a stalled response holds its
// payload and the block takes nothing new until rsp_ready takes it.
// Depends on bba_pkg, bba_ctrl, bba_dp and bba_ram.
module buddy_block_allocator_core
   import bba_pkg::*;
#(
   parameter int POOL_ORDER = 16,
   parameter int MIN_ORDER  = 6
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [ORD_W-1:0]   csr_wr_data,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_cmd,
   input  logic [SIZE_W-1:0]  req_request_size,
   input  logic [OFF_W-1:0]   req_block_offset,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [STAT_W-1:0]  rsp_status,
   output logic [OFF_W-1:0]   rsp_result_offset,
   output logic [ORD_W-1:0]   rsp_block_order,
   output logic [MSIZE_W-1:0] rsp_marked_size
);

   dp_cmd_type  dp_cmd;
   dp_stat_type dp_stat;

   bba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (dp_stat),
      .cmd       (dp_cmd)
   );

   bba_dp #(
      .POOL_ORDER (POOL_ORDER),
      .MIN_ORDER  (MIN_ORDER)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_cmd           (req_cmd),
      .req_request_size  (req_request_size),
      .req_block_offset  (req_block_offset),
      .cmd               (dp_cmd),
      .stat              (dp_stat),
      .rsp_status        (rsp_status),
      .rsp_result_offset (rsp_result_offset),
      .rsp_block_order   (rsp_block_order),
      .rsp_marked_size   (rsp_marked_size)
   );

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && req_ready))
      else $error("request accepted while a response is pending");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("ready stayed high after a request was taken");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STATUS_OK || rsp_status == STATUS_NO_MEM
                     || rsp_status == STATUS_BAD_FREE))
      else $error("response carries an unknown status");

   a_clear_after_csr: assert property (@(posedge clock) disable iff (reset)
      csr_wr_en |=> (!req_ready && !rsp_valid))
      else $error("block not clearing after a limit write");

endmodule

// ===== test/tb_top.sv =====
// tb_top: self-checking testbench for buddy_block_allocator_core.
// Holds a free-map predictor and a response scoreboard class; depends on bba_pkg and the RTL.
`timescale 1ns / 100ps

import bba_pkg::*;

class alloc_scoreboard;
   typedef struct packed {
      logic [STAT_W-1:0]  status;
      logic [OFF_W-1:0]   offset;
      logic [ORD_W-1:0]   order;
      logic [MSIZE_W-1:0] msize;
   } rsp_type;

   localparam int POOL = 16;
   localparam int MINO = 6;
   localparam int NODES = 2047;

   bit      node_free[NODES];
   int      free_cnt[11];
   int      limit;
   rsp_type pending[$];
   int      errors;

   function int idx(int ord, int pos);
      int i;
      i = ((1 << (POOL - ord)) - 1) + pos;
      return (i < NODES) ? i : 0;
   endfunction

   function void set_free(int ord, int pos, bit f);
      int i;
      i = idx(ord, pos);
      if (node_free[i] == f) return;
      node_free[i] = f;
      if (f) free_cnt[ord - MINO]++;
      else free_cnt[ord - MINO]--;
   endfunction

   function int clog2(int x);
      int n;
      int v;
      n = 0;
      v = x - 1;
      while (v != 0) begin
         n++;
         v = v >> 1;
      end
      return n;
   endfunction

   function void set_limit(int v);
      if (v < MINO) v = MINO;
      if (v > POOL) v = POOL;
      limit = v;
      foreach (node_free[i]) node_free[i] = 0;
      foreach (free_cnt[i]) free_cnt[i] = 0;
      set_free(limit, 0, 1);
   endfunction

   function new();
      errors = 0;
      set_limit(POOL);
   endfunction

   function void push(logic [1:0] st, int off, int ord, int ms);
      rsp_type r;
      r.status = st;
      r.offset = off[15:0];
      r.order = ord[4:0];
      r.msize = ms[16:0];
      pending.push_back(r);
   endfunction

   function void predict_alloc(int size);
      int m;
      int ord;
      int k;
      int p;
      bit found;
      m = size + 32;
      m = m + 32 - (m % 32);
      ord = clog2(m);
      if (ord < MINO) ord = MINO;
      if (ord > limit) begin
         push(STATUS_NO_MEM, 0, ord, m);
         return;
      end
      for (k = ord; k <= limit; k++)
         if (free_cnt[k - MINO] != 0) break;
      if (k > limit) begin
         push(STATUS_NO_MEM, 0, ord, m);
         return;
      end
      found = 0;
      p = 0;
      for (int j = 0; j < (1 << (limit - k)); j++)
         if (node_free[idx(k, j)]) begin
            p = j;
            found = 1;
            break;
         end
      if (!found) begin
         push(STATUS_NO_MEM, 0, ord, m);
         return;
      end
      for (int j = k; j > ord; j--) begin
         set_free(j, p, 0);
         set_free(j - 1, 2 * p, 1);
         set_free(j - 1, 2 * p + 1, 1);
         p = 2 * p;
      end
      set_free(ord, p, 0);
      push(STATUS_OK, p << ord, ord, m);
   endfunction

   function void predict_free(int size, int off);
      int s;
      int ord;
      int p;
      int span;
      s = (size == 0) ? 65536 : size;
      ord = clog2(s);
      if (ord < MINO) ord = MINO;
      if (ord > limit || (off & ((1 << ord) - 1)) != 0
          || (off >> ord) >= (1 << (limit - ord))) begin
         push(STATUS_BAD_FREE, off, ord, s);
         return;
      end
      p = off >> ord;
      for (int j = ord; j <= limit; j++)
         if (node_free[idx(j, p >> (j - ord))]) begin
            push(STATUS_BAD_FREE, off, ord, s);
            return;
         end
      for (int j = ord; j > MINO; j--) begin
         span = 1 << (ord - (j - 1));
         for (int q = 0; q < span; q++)
            if (node_free[idx(j - 1, p * span + q)]) begin
               push(STATUS_BAD_FREE, off, ord, s);
               return;
            end
      end
      while (ord < limit && node_free[idx(ord, p ^ 1)]) begin
         set_free(ord, p ^ 1, 0);
         p = p >> 1;
         ord++;
      end
      set_free(ord, p, 1);
      push(STATUS_OK, p << ord, ord, s);
   endfunction

   function void note_request(logic cmd, int size, int off);
      if (cmd == CMD_ALLOC) predict_alloc(size);
      else predict_free(size, off);
   endfunction

   function void check_response(rsp_type got);
      rsp_type exp;
      if (pending.size() == 0) begin
         $error("unexpected response %h", got);
         errors++;
         return;
      end
      exp = pending.pop_front();
      if (got.status !== exp.status) begin
         $error("status exp %0d got %0d", exp.status, got.status);
         errors++;
      end
      if (got.offset !== exp.offset) begin
         $error("result_offset exp %0h got %0h", exp.offset, got.offset);
         errors++;
      end
      if (got.order !== exp.order) begin
         $error("block_order exp %0d got %0d", exp.order, got.order);
         errors++;
      end
      if (got.msize !== exp.msize) begin
         $error("marked_size exp %0h got %0h", exp.msize, got.msize);
         errors++;
      end
   endfunction
endclass

module tb_top;
   logic               clock = 0;
   logic               reset = 1;
   logic               csr_wr_en = 0;
   logic [ORD_W-1:0]   csr_wr_data = '0;
   logic               req_valid = 0;
   logic               req_ready;
   logic               req_cmd = 0;
   logic [SIZE_W-1:0]  req_request_size = '0;
   logic [OFF_W-1:0]   req_block_offset = '0;
   logic               rsp_valid;
   logic               rsp_ready = 0;
   logic [STAT_W-1:0]  rsp_status;
   logic [OFF_W-1:0]   rsp_result_offset;
   logic [ORD_W-1:0]   rsp_block_order;
   logic [MSIZE_W-1:0] rsp_marked_size;

   alloc_scoreboard sb = new();
   int send_idle_pct;
   int recv_idle_pct;
   longint cycles;
   // live blocks: offset and marked size, for well-formed frees
   int live_off[$];
   int live_size[$];
   logic last_cmd_q[$];

   buddy_block_allocator_core dut (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_valid(req_valid), .req_ready(req_ready), .req_cmd(req_cmd),
      .req_request_size(req_request_size), .req_block_offset(req_block_offset),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
      .rsp_result_offset(rsp_result_offset), .rsp_block_order(rsp_block_order),
      .rsp_marked_size(rsp_marked_size)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 3000000) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial cycles = 0;

   // response side: random stall, check on handshake
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            sb.check_response({rsp_status, rsp_result_offset, rsp_block_order,
                               rsp_marked_size});
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // track allocations from responses to build legal frees
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready && rsp_status == STATUS_OK
          && rsp_marked_size != 0 && last_cmd_q.size() > 0) begin
         if (last_cmd_q[0] == CMD_ALLOC) begin
            live_off.push_back(rsp_result_offset);
            live_size.push_back(rsp_marked_size);
         end
      end
      if (!reset && rsp_valid && rsp_ready && last_cmd_q.size() > 0)
         void'(last_cmd_q.pop_front());
   end

   task automatic send(logic cmd, int size, int off);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_cmd <= cmd;
      req_request_size <= size[15:0];
      req_block_offset <= off[15:0];
      do @(posedge clock); while (!req_ready);
      sb.note_request(cmd, int'(size[15:0]), int'(off[15:0]));
      last_cmd_q.push_back(cmd);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_limit(int v);
      drain();
      csr_wr_en <= 1;
      csr_wr_data <= v[4:0];
      @(posedge clock);
      csr_wr_en <= 0;
      sb.set_limit(v);
      live_off.delete();
      live_size.delete();
   endtask

   task automatic random_item();
      int r;
      int i;
      r = $urandom_range(99);
      if (r < 45) send(CMD_ALLOC, $urandom_range(sb.limit > 10 ? 3000 : 200), 0);
      else if (r < 85 && live_off.size() > 0) begin
         i = $urandom_range(live_off.size() - 1);
         send(CMD_FREE, live_size[i], live_off[i]);
         live_off.delete(i);
         live_size.delete(i);
      end else if (r < 92) send(CMD_ALLOC, $urandom, $urandom);
      else send(CMD_FREE, $urandom, $urandom_range(1) ? $urandom : ($urandom & 16'hffc0));
   endtask

   initial begin
      send_idle_pct = 10;
      recv_idle_pct = 66;
      repeat (9) @(posedge clock);
      reset <= 0;
      // directed
      send(CMD_ALLOC, 0, 0);
      send(CMD_ALLOC, 31, 0);
      send(CMD_ALLOC, 32, 0);
      send(CMD_ALLOC, 65535, 16'hffff);
      send(CMD_FREE, 64, 0);
      send(CMD_FREE, 64, 0);
      send(CMD_FREE, 1, 64);
      send(CMD_FREE, 64, 3);
      send(CMD_FREE, 0, 0);
      send(CMD_FREE, 16'hffff, 16'hffff);
      send(CMD_FREE, 96, 128);
      send(CMD_FREE, 128, 128);
      send(CMD_FREE, 64, 64);
      send(CMD_FREE, 0, 0);
      send(CMD_ALLOC, 65535 - 64, 0);
      send(CMD_ALLOC, 60000, 0);
      send(CMD_ALLOC, 1, 0);
      write_limit(0);
      send(CMD_ALLOC, 0, 0);
      send(CMD_ALLOC, 0, 0);
      send(CMD_FREE, 64, 64);
      write_limit(31);
      send(CMD_ALLOC, 30000, 0);
      send(CMD_FREE, 0, 0);
      // random phases
      for (int ph = 0; ph < 6; ph++) begin
         if (ph == 2) begin
            send_idle_pct = 66;
            recv_idle_pct = 10;
         end
         if (ph == 4) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         write_limit(ph == 0 ? 6 : ph == 5 ? 16 : $urandom_range(6, 16));
         for (int n = 0; n < 90; n++) random_item();
      end
      drain();
      if (sb.errors == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end
endmodule
